/* rtl/phs_pkg.sv */
package phs_pkg;

  // width of a position difference and of the vectors fed to the normalizer
  localparam int VEC_W      = 34;
  localparam int UNIT_W     = 16;
  localparam int POS_W      = 6;
  localparam int NORM_W     = 24;
  localparam int NORM_MSB   = 23;
  localparam int SQ_W       = 2 * NORM_W;
  localparam int ACC_W      = 52;
  localparam int ROOT_W     = 25;
  localparam int SQRT_STEPS = 26;
  localparam int QUO_W      = 15;
  localparam int DIV_STEPS  = 15;
  localparam int DIV_W      = 40;
  localparam int UNIT_FRAC  = 14;
  localparam int UNIT_LAT   = 5 + SQRT_STEPS + DIV_STEPS + 1;

  localparam int PW_W       = 29;
  localparam int POW_BITS   = 8;
  localparam logic [PW_W-1:0] PW_ONE = 29'h1000_0000;

  localparam logic [16:0] GAIN_RST = 17'd13107;
  localparam logic [7:0]  SHIN_RST = 8'd32;

  typedef logic signed [VEC_W-1:0]  vec_t;
  typedef logic signed [UNIT_W-1:0] unit_t;

  typedef enum logic [2:0] {
    CFG_LIGHT_X  = 3'd0,
    CFG_LIGHT_Y  = 3'd1,
    CFG_LIGHT_Z  = 3'd2,
    CFG_CAMERA_X = 3'd3,
    CFG_CAMERA_Y = 3'd4,
    CFG_CAMERA_Z = 3'd5,
    CFG_GAIN     = 3'd6,
    CFG_SHINE    = 3'd7
  } cfg_reg_e;

  typedef struct packed {
    logic [7:0] ambient_red;
    logic [7:0] ambient_green;
    logic [7:0] ambient_blue;
    logic [7:0] diffuse_red;
    logic [7:0] diffuse_green;
    logic [7:0] diffuse_blue;
    logic [7:0] specular_level;
  } shade_t;

endpackage

/* rtl/phs_pix_if.sv */
interface phs_pix_if;
  logic               valid;
  logic               ready;
  logic [7:0]         color_red;
  logic [7:0]         color_green;
  logic [7:0]         color_blue;
  logic signed [15:0] normal_x;
  logic signed [15:0] normal_y;
  logic signed [15:0] normal_z;
  logic signed [31:0] hit_x;
  logic signed [31:0] hit_y;
  logic signed [31:0] hit_z;

  modport source (
    output valid, color_red, color_green, color_blue,
    output normal_x, normal_y, normal_z, hit_x, hit_y, hit_z,
    input  ready
  );
  modport sink (
    input  valid, color_red, color_green, color_blue,
    input  normal_x, normal_y, normal_z, hit_x, hit_y, hit_z,
    output ready
  );
endinterface

/* rtl/phs_shade_if.sv */
interface phs_shade_if;
  logic       valid;
  logic       ready;
  logic [7:0] ambient_red;
  logic [7:0] ambient_green;
  logic [7:0] ambient_blue;
  logic [7:0] diffuse_red;
  logic [7:0] diffuse_green;
  logic [7:0] diffuse_blue;
  logic [7:0] specular_level;

  modport source (
    output valid, ambient_red, ambient_green, ambient_blue,
    output diffuse_red, diffuse_green, diffuse_blue, specular_level,
    input  ready
  );
  modport sink (
    input  valid, ambient_red, ambient_green, ambient_blue,
    input  diffuse_red, diffuse_green, diffuse_blue, specular_level,
    output ready
  );
endinterface

/* rtl/phs_unitize.sv */
module phs_unitize import phs_pkg::*; (
  input  logic  clk_i,
  input  logic  en_i,
  input  vec_t  vec_i [3],
  output unit_t unit_o [3]
);

  // stage 1: magnitudes and largest magnitude
  logic [VEC_W-1:0] mag1_d [3];
  logic [VEC_W-1:0] mag1_q [3];
  logic             neg1_q [3];
  logic [VEC_W-1:0] mx1_d, mx1_q;

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      mag1_d[i] = vec_i[i][VEC_W-1] ? -vec_i[i] : vec_i[i];
    end
    mx1_d = mag1_d[0];
    if (mag1_d[1] > mx1_d) mx1_d = mag1_d[1];
    if (mag1_d[2] > mx1_d) mx1_d = mag1_d[2];
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        mag1_q[i] <= mag1_d[i];
        neg1_q[i] <= vec_i[i][VEC_W-1];
      end
      mx1_q <= mx1_d;
    end
  end

  // stage 2: leading one of the largest magnitude
  logic [VEC_W-1:0] mag2_q [3];
  logic             neg2_q [3];
  logic [POS_W-1:0] pos2_d, pos2_q;
  logic             zero2_q;

  always_comb begin
    pos2_d = '0;
    for (int b = 0; b < VEC_W; b++) begin
      if (mx1_q[b]) pos2_d = POS_W'(b);
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      mag2_q  <= mag1_q;
      neg2_q  <= neg1_q;
      pos2_q  <= pos2_d;
      zero2_q <= (mx1_q == '0);
    end
  end

  // stage 3: common shift so the largest lands in [2^23, 2^24)
  logic [NORM_W-1:0] m3_d [3];
  logic [NORM_W-1:0] m3_q [3];
  logic              neg3_q [3];
  logic              zero3_q;

  always_comb begin
    logic [VEC_W-1:0] t;
    for (int i = 0; i < 3; i++) begin
      if (pos2_q >= POS_W'(NORM_MSB)) begin
        t = mag2_q[i] >> (pos2_q - POS_W'(NORM_MSB));
      end else begin
        t = mag2_q[i] << (POS_W'(NORM_MSB) - pos2_q);
      end
      m3_d[i] = t[NORM_W-1:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      m3_q    <= m3_d;
      neg3_q  <= neg2_q;
      zero3_q <= zero2_q;
    end
  end

  // stage 4: squares
  logic [SQ_W-1:0]   sq4_q [3];
  logic [NORM_W-1:0] m4_q [3];
  logic              neg4_q [3];
  logic              zero4_q;

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      for (int i = 0; i < 3; i++) begin
        sq4_q[i] <= SQ_W'(m3_q[i]) * SQ_W'(m3_q[i]);
      end
      m4_q    <= m3_q;
      neg4_q  <= neg3_q;
      zero4_q <= zero3_q;
    end
  end

  // stage 5 and on: sum of squares, then one root bit per stage
  logic [ACC_W-1:0]  sv_q [SQRT_STEPS+1];
  logic [ACC_W-1:0]  sr_q [SQRT_STEPS+1];
  logic [NORM_W-1:0] sm_q [SQRT_STEPS+1][3];
  logic              sneg_q [SQRT_STEPS+1][3];
  logic              sz_q [SQRT_STEPS+1];

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      sv_q[0]   <= ACC_W'(sq4_q[0]) + ACC_W'(sq4_q[1]) + ACC_W'(sq4_q[2]);
      sr_q[0]   <= '0;
      sm_q[0]   <= m4_q;
      sneg_q[0] <= neg4_q;
      sz_q[0]   <= zero4_q;
    end
  end

  for (genvar k = 0; k < SQRT_STEPS; k++) begin : g_sqrt
    localparam logic [ACC_W-1:0] BIT = ACC_W'(1) << (2 * (SQRT_STEPS - 1 - k));
    logic [ACC_W-1:0] trial;
    logic [ACC_W-1:0] v_d, r_d;

    always_comb begin
      trial = sr_q[k] + BIT;
      if (sv_q[k] >= trial) begin
        v_d = sv_q[k] - trial;
        r_d = (sr_q[k] >> 1) + BIT;
      end else begin
        v_d = sv_q[k];
        r_d = sr_q[k] >> 1;
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        sv_q[k+1]   <= v_d;
        sr_q[k+1]   <= r_d;
        sm_q[k+1]   <= sm_q[k];
        sneg_q[k+1] <= sneg_q[k];
        sz_q[k+1]   <= sz_q[k];
      end
    end
  end

  // restoring divide of each magnitude by the length, one quotient bit per stage
  logic [DIV_W-1:0]  dr_q [DIV_STEPS][3];
  logic [QUO_W-1:0]  dq_q [DIV_STEPS][3];
  logic [ROOT_W-1:0] ds_q [DIV_STEPS];
  logic              dneg_q [DIV_STEPS][3];
  logic              dz_q [DIV_STEPS];

  for (genvar j = 0; j < DIV_STEPS; j++) begin : g_div
    logic [DIV_W-1:0]  rem_in [3];
    logic [QUO_W-1:0]  q_in [3];
    logic [ROOT_W-1:0] s_in;
    logic              neg_in [3];
    logic              zero_in;
    logic [DIV_W-1:0]  shifted;
    logic [DIV_W-1:0]  rem_d [3];
    logic [QUO_W-1:0]  q_d [3];

    if (j == 0) begin : g_first
      always_comb begin
        for (int i = 0; i < 3; i++) begin
          rem_in[i] = DIV_W'(sm_q[SQRT_STEPS][i]) << UNIT_FRAC;
          q_in[i]   = '0;
        end
        s_in    = sr_q[SQRT_STEPS][ROOT_W-1:0];
        neg_in  = sneg_q[SQRT_STEPS];
        zero_in = sz_q[SQRT_STEPS];
      end
    end else begin : g_next
      always_comb begin
        rem_in  = dr_q[j-1];
        q_in    = dq_q[j-1];
        s_in    = ds_q[j-1];
        neg_in  = dneg_q[j-1];
        zero_in = dz_q[j-1];
      end
    end

    always_comb begin
      shifted = DIV_W'(s_in) << (DIV_STEPS - 1 - j);
      for (int i = 0; i < 3; i++) begin
        rem_d[i] = rem_in[i];
        q_d[i]   = q_in[i];
        if (rem_in[i] >= shifted) begin
          rem_d[i] = rem_in[i] - shifted;
          q_d[i][DIV_STEPS-1-j] = 1'b1;
        end
      end
    end

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        dr_q[j]   <= rem_d;
        dq_q[j]   <= q_d;
        ds_q[j]   <= s_in;
        dneg_q[j] <= neg_in;
        dz_q[j]   <= zero_in;
      end
    end
  end

  // sign and zero vector
  unit_t unit_d [3];
  unit_t unit_q [3];

  always_comb begin
    unit_t mag;
    for (int i = 0; i < 3; i++) begin
      mag = unit_t'({1'b0, dq_q[DIV_STEPS-1][i]});
      if (dz_q[DIV_STEPS-1]) begin
        unit_d[i] = '0;
      end else if (dneg_q[DIV_STEPS-1][i]) begin
        unit_d[i] = -mag;
      end else begin
        unit_d[i] = mag;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (en_i) begin
      unit_q <= unit_d;
    end
  end

  assign unit_o = unit_q;

endmodule

/* rtl/phong_shading.sv */
// Phong shading of one hit point per transaction.
// pix_i carries the surface colour, the Q1.14 normal and the Q16.16 hit point;
// shade_o returns the ambient colour, the diffuse colour and a white specular
// level, each 8 bits, truncated and saturated at 255.
// Light and camera positions, ambient gain and shininess are written through
// cfg_we_i / cfg_idx_i / cfg_data_i; the user must write them only while no
// transaction is in flight, as the block does not enforce it. Throughput is
// one transaction per cycle while pix_i.ready is high. Each passes through an
// input register, two 47 stage vector normalizers in series (the second one
// works on the reflected light direction), dot product and reflection stages,
// 16 stages of exponentiation by squaring and one output stage. Each
// normalizer spends 26 stages on the square root and 15 stages on the divide.
// Reset clears all valid bits and loads the register defaults (light and
// camera at the origin, gain 0.2, shininess 32).
// When shade_o is stalled the finished result holds and a one entry skid
// register takes the next result; pix_i.ready falls only while that skid
// entry is full, and the whole pipeline holds with it.
module phong_shading import phs_pkg::*; (
  input  logic        clk_i,
  input  logic        rst_ni,
  phs_pix_if.sink     pix_i,
  phs_shade_if.source shade_o,
  input  logic        cfg_we_i,
  input  logic [2:0]  cfg_idx_i,
  input  logic [31:0] cfg_data_i
);

  localparam int UL    = UNIT_LAT;
  localparam int DEPTH = 2 * UL + 24;
  localparam int RIN   = UL + 4;
  localparam int RVP   = 2 * UL + 5;
  localparam int PWN   = 2 * UL + 22;

  // configuration
  logic signed [31:0] light_q [3];
  logic signed [31:0] camera_q [3];
  logic [16:0]        gain_q;
  logic [7:0]         shin_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      light_q  <= '{default: '0};
      camera_q <= '{default: '0};
      gain_q   <= GAIN_RST;
      shin_q   <= SHIN_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_LIGHT_X:  light_q[0]  <= cfg_data_i;
        CFG_LIGHT_Y:  light_q[1]  <= cfg_data_i;
        CFG_LIGHT_Z:  light_q[2]  <= cfg_data_i;
        CFG_CAMERA_X: camera_q[0] <= cfg_data_i;
        CFG_CAMERA_Y: camera_q[1] <= cfg_data_i;
        CFG_CAMERA_Z: camera_q[2] <= cfg_data_i;
        CFG_GAIN:     gain_q      <= cfg_data_i[16:0];
        CFG_SHINE:    shin_q      <= cfg_data_i[7:0];
        default: ;
      endcase
    end
  end

  // flow control
  logic   en;
  logic   vld_q [DEPTH];
  shade_t fin_q;
  shade_t out_q, skid_q;
  logic   out_v_q, skid_v_q;

  assign en          = !skid_v_q;
  assign pix_i.ready = en;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '{default: 1'b0};
    end else if (en) begin
      vld_q[0] <= pix_i.valid;
      for (int k = 1; k < DEPTH; k++) begin
        vld_q[k] <= vld_q[k-1];
      end
    end
  end

  // input stage: direction differences
  logic signed [31:0] hit [3];
  vec_t               dl_q [3];
  vec_t               dv_q [3];
  logic [7:0]         col_q [PWN+1][3];
  unit_t              n_q [RIN-1][3];

  assign hit[0] = pix_i.hit_x;
  assign hit[1] = pix_i.hit_y;
  assign hit[2] = pix_i.hit_z;

  always_ff @(posedge clk_i) begin
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        dl_q[i] <= vec_t'(light_q[i]) - vec_t'(hit[i]);
        dv_q[i] <= vec_t'(camera_q[i]) - vec_t'(hit[i]);
      end
      col_q[0] <= '{pix_i.color_red, pix_i.color_green, pix_i.color_blue};
      n_q[0]   <= '{pix_i.normal_x, pix_i.normal_y, pix_i.normal_z};
      for (int k = 1; k <= PWN; k++) begin
        col_q[k] <= col_q[k-1];
      end
      for (int k = 1; k < RIN - 1; k++) begin
        n_q[k] <= n_q[k-1];
      end
    end
  end

  unit_t l_u [3];
  unit_t v_u [3];

  phs_unitize u_unit_l (.clk_i(clk_i), .en_i(en), .vec_i(dl_q), .unit_o(l_u));
  phs_unitize u_unit_v (.clk_i(clk_i), .en_i(en), .vec_i(dv_q), .unit_o(v_u));

  // n.l, reflection
  logic signed [31:0] nlp_q [3];
  logic signed [33:0] nl_q;
  logic signed [19:0] dq;
  logic signed [33:0] nl_bias;
  logic signed [36:0] dn_q [3];
  unit_t              l_q [UL+1:UL+3][3];
  vec_t               r_q [3];
  logic [32:0]        cosd_q [UL+3:PWN];

  always_comb begin
    nl_bias = nl_q + ((nl_q < 0) ? 34'sd16383 : 34'sd0);
    dq      = 20'(nl_bias >>> UNIT_FRAC);
  end

  always_ff @(posedge clk_i) begin
    logic signed [36:0] dn_b;
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        nlp_q[i] <= 32'(n_q[UL][i]) * 32'(l_u[i]);
      end
      l_q[UL+1] <= l_u;
      l_q[UL+2] <= l_q[UL+1];
      l_q[UL+3] <= l_q[UL+2];
      nl_q <= 34'(nlp_q[0]) + 34'(nlp_q[1]) + 34'(nlp_q[2]);
      for (int i = 0; i < 3; i++) begin
        dn_q[i] <= (37'(dq) * 37'(n_q[RIN-2][i])) <<< 1;
      end
      cosd_q[UL+3] <= (nl_q > 0) ? nl_q[32:0] : '0;
      for (int k = UL + 4; k <= PWN; k++) begin
        cosd_q[k] <= cosd_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        dn_b    = dn_q[i] + ((dn_q[i] < 0) ? 37'sd16383 : 37'sd0);
        r_q[i] <= vec_t'(dn_b >>> UNIT_FRAC) - vec_t'(l_q[UL+3][i]);
      end
    end
  end

  unit_t u_u [3];

  phs_unitize u_unit_r (.clk_i(clk_i), .en_i(en), .vec_i(r_q), .unit_o(u_u));

  // r.v and clamp
  unit_t              v_q [UL+1:RVP-1][3];
  logic signed [31:0] rvp_q [3];
  logic signed [33:0] rv;
  logic [PW_W-1:0]    c_d;

  always_comb begin
    rv = 34'(rvp_q[0]) + 34'(rvp_q[1]) + 34'(rvp_q[2]);
    if (rv <= 0) begin
      c_d = '0;
    end else if (rv > 34'(PW_ONE)) begin
      c_d = PW_ONE;
    end else begin
      c_d = rv[PW_W-1:0];
    end
  end

  // exponent by squaring, most significant bit first
  logic [PW_W-1:0] pp_q [2*POW_BITS+1];
  logic [PW_W-1:0] pc_q [2*POW_BITS+1];

  always_ff @(posedge clk_i) begin
    if (en) begin
      v_q[UL+1] <= v_u;
      for (int k = UL + 2; k < RVP; k++) begin
        v_q[k] <= v_q[k-1];
      end
      for (int i = 0; i < 3; i++) begin
        rvp_q[i] <= 32'(u_u[i]) * 32'(v_q[RVP-1][i]);
      end
      pp_q[0] <= PW_ONE;
      pc_q[0] <= c_d;
    end
  end

  for (genvar k = 0; k < 2 * POW_BITS; k++) begin : g_pow
    logic [2*PW_W-1:0] prod;
    logic [PW_W-1:0]   p_d;

    always_comb begin
      if (k % 2 == 0) begin
        prod = (2*PW_W)'(pp_q[k]) * (2*PW_W)'(pp_q[k]);
        p_d  = prod[2*PW_W-2:28];
      end else begin
        prod = (2*PW_W)'(pp_q[k]) * (2*PW_W)'(pc_q[k]);
        p_d  = shin_q[POW_BITS-1-k/2] ? prod[2*PW_W-2:28] : pp_q[k];
      end
    end

    always_ff @(posedge clk_i) begin
      if (en) begin
        pp_q[k+1] <= p_d;
        pc_q[k+1] <= pc_q[k];
      end
    end
  end

  // output terms
  function automatic logic [7:0] sat8(input logic [12:0] v);
    return (v > 13'd255) ? 8'd255 : v[7:0];
  endfunction

  always_ff @(posedge clk_i) begin
    logic [24:0] amb;
    logic [40:0] dif;
    logic [36:0] spc;
    logic [7:0]  a [3];
    logic [7:0]  d [3];
    if (en) begin
      for (int i = 0; i < 3; i++) begin
        amb  = 25'(col_q[PWN][i]) * 25'(gain_q);
        dif  = 41'(col_q[PWN][i]) * 41'(cosd_q[PWN]);
        a[i] = sat8(13'(amb[24:16]));
        d[i] = sat8(dif[40:28]);
      end
      spc = 37'd255 * 37'(pp_q[2*POW_BITS]);
      fin_q <= '{ambient_red: a[0], ambient_green: a[1], ambient_blue: a[2],
                 diffuse_red: d[0], diffuse_green: d[1], diffuse_blue: d[2],
                 specular_level: sat8(13'(spc[36:28]))};
    end
  end

  // output register with skid entry
  logic arrive;
  logic take;

  assign arrive = en && vld_q[DEPTH-1];
  assign take   = shade_o.ready || !out_v_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q  <= 1'b0;
      skid_v_q <= 1'b0;
    end else if (take) begin
      out_v_q  <= skid_v_q || arrive;
      skid_v_q <= 1'b0;
    end else if (arrive) begin
      skid_v_q <= 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (take) begin
      out_q <= skid_v_q ? skid_q : fin_q;
    end else if (arrive) begin
      skid_q <= fin_q;
    end
  end

  assign shade_o.valid          = out_v_q;
  assign shade_o.ambient_red    = out_q.ambient_red;
  assign shade_o.ambient_green  = out_q.ambient_green;
  assign shade_o.ambient_blue   = out_q.ambient_blue;
  assign shade_o.diffuse_red    = out_q.diffuse_red;
  assign shade_o.diffuse_green  = out_q.diffuse_green;
  assign shade_o.diffuse_blue   = out_q.diffuse_blue;
  assign shade_o.specular_level = out_q.specular_level;

endmodule

/* rtl/phs_checker.sv */
module phs_checker (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        in_ready_i,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [55:0] out_data_i
);

  // a held result keeps its value
  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i && $stable(out_data_i))
    else $error("result changed while stalled");

  // input side only backs up behind a waiting result
  a_ready_low_has_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i |-> out_valid_i)
    else $error("input stalled with no result waiting");

  a_ready_stays_low: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && !out_ready_i |=> !in_ready_i)
    else $error("input released while output still stalled");

  a_ready_recovers: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !in_ready_i && out_ready_i |=> in_ready_i)
    else $error("input not released after output drained");

endmodule

bind phong_shading phs_checker u_phs_checker (
  .clk_i       (clk_i),
  .rst_ni      (rst_ni),
  .in_ready_i  (pix_i.ready),
  .out_valid_i (shade_o.valid),
  .out_ready_i (shade_o.ready),
  .out_data_i  ({shade_o.ambient_red, shade_o.ambient_green, shade_o.ambient_blue,
                 shade_o.diffuse_red, shade_o.diffuse_green, shade_o.diffuse_blue,
                 shade_o.specular_level})
);
